// ----- rtl/prr_pkg.sv -----
// Shared types and constants for the pinhole reprojection residual unit.
package prr_pkg;

    localparam int WORD_W   = 32;
    localparam int CFG_W    = 64;
    localparam int NUM_POSE = 6;
    localparam int IDX_W    = 3;
    localparam int FOCAL    = 500;
    localparam int DEN_W    = 32;

    typedef logic [IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t POSE_WORD_0 = 3'd0;
    localparam cfg_idx_t POSE_WORD_1 = 3'd1;
    localparam cfg_idx_t POSE_WORD_2 = 3'd2;
    localparam cfg_idx_t POSE_WORD_3 = 3'd3;
    localparam cfg_idx_t POSE_WORD_4 = 3'd4;
    localparam cfg_idx_t POSE_WORD_5 = 3'd5;

    // r00 r01 r02 r10 r11 r12 r20 r21 r22 tx ty tz
    typedef logic [11:0][WORD_W-1:0] pose_t;

    typedef struct packed {
        logic [WORD_W-1:0] seen_x;
        logic [WORD_W-1:0] seen_y;
        logic              neg_x;
        logic              neg_y;
        logic              depth_zero;
        logic              sat;
    } side_t;

endpackage

// ----- rtl/prr_point_if.sv -----
// Input channel carrying one point and observed pixel per word.
interface prr_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] point_w;
    logic signed [31:0] seen_x;
    logic signed [31:0] seen_y;

    modport source (output valid, point_x, point_y, point_z, point_w, seen_x, seen_y,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, point_w, seen_x, seen_y,
                  output ready);
endinterface

// ----- rtl/prr_resid_if.sv -----
// Output channel carrying one residual word.
interface prr_resid_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] residual_x;
    logic signed [31:0] residual_y;
    logic               depth_zero;
    logic               saturated;

    modport source (output valid, residual_x, residual_y, depth_zero, saturated,
                    input ready);
    modport sink (input valid, residual_x, residual_y, depth_zero, saturated,
                  output ready);
endinterface

// ----- rtl/pinhole_reprojection_residual_unit.sv -----
// Throughput: one word per cycle while the output is not stalled.
// Three transform stages, one divider stage per quotient bit (FRAC_BITS + 40 of
// them), one output register.
// A full output register with ready low holds the whole pipeline.
// Reset clears all valid bits and loads the identity pose.
module pinhole_reprojection_residual_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  prr_pkg::cfg_idx_t        cfg_index,
    input  logic [prr_pkg::CFG_W-1:0] cfg_data,
    prr_point_if.sink                points,
    prr_resid_if.source              residuals
);

    localparam int NUM_W = 40 + FRAC_BITS;
    localparam int RES_W = 40;
    localparam logic [63:0] OFF_X = ((64'd3251 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [63:0] OFF_Y = ((64'd2507 << FRAC_BITS) + 64'd5) / 64'd10;

    logic [prr_pkg::CFG_W-1:0] pose_reg [prr_pkg::NUM_POSE];
    prr_pkg::pose_t            pose;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_reg[0] <= 64'd65536;
            pose_reg[1] <= 64'd0;
            pose_reg[2] <= 64'd65536;
            pose_reg[3] <= 64'd0;
            pose_reg[4] <= 64'd65536;
            pose_reg[5] <= 64'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                prr_pkg::POSE_WORD_0: pose_reg[0] <= cfg_data;
                prr_pkg::POSE_WORD_1: pose_reg[1] <= cfg_data;
                prr_pkg::POSE_WORD_2: pose_reg[2] <= cfg_data;
                prr_pkg::POSE_WORD_3: pose_reg[3] <= cfg_data;
                prr_pkg::POSE_WORD_4: pose_reg[4] <= cfg_data;
                prr_pkg::POSE_WORD_5: pose_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < prr_pkg::NUM_POSE; k++)
        begin
            pose[2*k]   = pose_reg[k][31:0];
            pose[2*k+1] = pose_reg[k][63:32];
        end
    end

    logic en;
    logic out_v_reg;
    assign en = !out_v_reg || residuals.ready;
    assign points.ready = en;

    logic                      xf_valid;
    logic [NUM_W-1:0]          xf_num_x, xf_num_y;
    logic [prr_pkg::DEN_W-1:0] xf_den;
    prr_pkg::side_t            xf_side;

    prr_xform #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (points.valid),
        .point_x   (points.point_x),
        .point_y   (points.point_y),
        .point_z   (points.point_z),
        .point_w   (points.point_w),
        .seen_x    (points.seen_x),
        .seen_y    (points.seen_y),
        .pose      (pose),
        .out_valid (xf_valid),
        .num_x     (xf_num_x),
        .num_y     (xf_num_y),
        .den       (xf_den),
        .side      (xf_side)
    );

    logic             dv_valid;
    logic [NUM_W-1:0] dv_qx, dv_qy;
    prr_pkg::side_t   dv_side;

    prr_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xf_valid),
        .num_x     (xf_num_x),
        .num_y     (xf_num_y),
        .den       (xf_den),
        .in_side   (xf_side),
        .out_valid (dv_valid),
        .quo_x     (dv_qx),
        .quo_y     (dv_qy),
        .out_side  (dv_side)
    );

    // sign, clip, subtract
    logic [31:0]             proj_x, proj_y;
    logic                    psat_x, psat_y;
    logic signed [RES_W-1:0] rx, ry;
    logic                    rsat_x, rsat_y;
    logic [31:0]             res_x_next, res_y_next;
    logic                    dz_next, sat_next;

    always_comb
    begin
        logic hx, hy;
        hx = |dv_qx[NUM_W-1:32];
        hy = |dv_qy[NUM_W-1:32];
        if (dv_side.neg_x)
        begin
            psat_x = hx || (dv_qx[31] && (|dv_qx[30:0]));
            proj_x = psat_x ? 32'h8000_0000 : (~dv_qx[31:0] + 32'd1);
        end
        else
        begin
            psat_x = hx || dv_qx[31];
            proj_x = psat_x ? 32'h7FFF_FFFF : dv_qx[31:0];
        end
        if (dv_side.neg_y)
        begin
            psat_y = hy || (dv_qy[31] && (|dv_qy[30:0]));
            proj_y = psat_y ? 32'h8000_0000 : (~dv_qy[31:0] + 32'd1);
        end
        else
        begin
            psat_y = hy || dv_qy[31];
            proj_y = psat_y ? 32'h7FFF_FFFF : dv_qy[31:0];
        end

        rx = RES_W'($signed(dv_side.seen_x)) - RES_W'($signed(proj_x))
             - $signed(RES_W'(OFF_X));
        ry = RES_W'($signed(dv_side.seen_y)) - RES_W'($signed(proj_y))
             - $signed(RES_W'(OFF_Y));

        rsat_x = rx[RES_W-1:31] != {(RES_W-31){rx[31]}};
        rsat_y = ry[RES_W-1:31] != {(RES_W-31){ry[31]}};

        if (dv_side.depth_zero)
        begin
            res_x_next = 32'h7FFF_FFFF;
            res_y_next = 32'h7FFF_FFFF;
            dz_next    = 1'b1;
            sat_next   = 1'b1;
        end
        else
        begin
            res_x_next = rsat_x ? (rx[RES_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : rx[31:0];
            res_y_next = rsat_y ? (ry[RES_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : ry[31:0];
            dz_next    = 1'b0;
            sat_next   = dv_side.sat || psat_x || psat_y || rsat_x || rsat_y;
        end
    end

    logic [31:0] res_x_reg, res_y_reg;
    logic        dz_reg, sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_x_reg <= res_x_next;
            res_y_reg <= res_y_next;
            dz_reg    <= dz_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= dv_valid;
    end

    assign residuals.valid      = out_v_reg;
    assign residuals.residual_x = res_x_reg;
    assign residuals.residual_y = res_y_reg;
    assign residuals.depth_zero = dz_reg;
    assign residuals.saturated  = sat_reg;

endmodule

// ----- rtl/prr_xform.sv -----
// Pose transform: products, rounded row sums, divider operand preparation.
module prr_xform #(
    parameter int FRAC_BITS = 16,
    parameter int NUM_W     = 56
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [31:0]            point_x,
    input  logic signed [31:0]            point_y,
    input  logic signed [31:0]            point_z,
    input  logic signed [31:0]            point_w,
    input  logic signed [31:0]            seen_x,
    input  logic signed [31:0]            seen_y,
    input  prr_pkg::pose_t                pose,
    output logic                          out_valid,
    output logic [NUM_W-1:0]              num_x,
    output logic [NUM_W-1:0]              num_y,
    output logic [prr_pkg::DEN_W-1:0]     den,
    output prr_pkg::side_t                side
);

    localparam int RND_W = 65 - FRAC_BITS;
    localparam int SUM_W = RND_W + 2;
    localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);

    logic signed [31:0] pt [4];
    logic signed [63:0] prod_reg [3][4];
    logic [31:0]        seen_x1_reg, seen_y1_reg;
    logic               v1_reg;

    logic signed [31:0] cam_reg [3];
    logic [31:0]        cam_next [3];
    logic [2:0]         csat;
    logic [31:0]        seen_x2_reg, seen_y2_reg;
    logic               sat2_reg;
    logic               v2_reg;

    logic               v3_reg;
    logic [NUM_W-1:0]   num_x_reg, num_y_reg;
    logic [31:0]        den_reg;
    prr_pkg::side_t     side_reg;

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;
    assign pt[3] = point_w;

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    prod_reg[i][j] <= $signed(pose[i*3+j]) * pt[j];
                prod_reg[i][3] <= $signed(pose[9+i]) * pt[3];
            end
            seen_x1_reg <= seen_x;
            seen_y1_reg <= seen_y;
        end
    end

    // stage 2: round, row sum, clip
    always_comb
    begin
        logic signed [64:0]      t;
        logic signed [RND_W-1:0] r;
        logic signed [SUM_W-1:0] s;
        for (int i = 0; i < 3; i++)
        begin
            s = '0;
            for (int j = 0; j < 4; j++)
            begin
                t = 65'(prod_reg[i][j]) + HALF;
                r = RND_W'(t >>> FRAC_BITS);
                s = s + SUM_W'(r);
            end
            if (s[SUM_W-1:31] == {(SUM_W-31){s[31]}})
            begin
                cam_next[i] = s[31:0];
                csat[i] = 1'b0;
            end
            else
            begin
                cam_next[i] = s[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                csat[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                cam_reg[i] <= cam_next[i];
            sat2_reg    <= |csat;
            seen_x2_reg <= seen_x1_reg;
            seen_y2_reg <= seen_y1_reg;
        end
    end

    // stage 3: magnitudes and scaled numerators
    logic [31:0] mag_x, mag_y, mag_z;
    assign mag_x = cam_reg[0][31] ? (~cam_reg[0] + 32'd1) : cam_reg[0];
    assign mag_y = cam_reg[1][31] ? (~cam_reg[1] + 32'd1) : cam_reg[1];
    assign mag_z = cam_reg[2][31] ? (~cam_reg[2] + 32'd1) : cam_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_x_reg <= NUM_W'(41'(mag_x) * 41'(prr_pkg::FOCAL)) << FRAC_BITS;
            num_y_reg <= NUM_W'(41'(mag_y) * 41'(prr_pkg::FOCAL)) << FRAC_BITS;
            den_reg   <= mag_z;
            side_reg.seen_x     <= seen_x2_reg;
            side_reg.seen_y     <= seen_y2_reg;
            side_reg.neg_x      <= cam_reg[0][31] ^ cam_reg[2][31];
            side_reg.neg_y      <= cam_reg[1][31] ^ cam_reg[2][31];
            side_reg.depth_zero <= (cam_reg[2] == 32'd0);
            side_reg.sat        <= sat2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign num_x     = num_x_reg;
    assign num_y     = num_y_reg;
    assign den       = den_reg;
    assign side      = side_reg;

endmodule

// ----- rtl/prr_div.sv -----
// Pipelined restoring divider, two numerators over one divisor, one bit per stage.
module prr_div #(
    parameter int NUM_W = 56
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [NUM_W-1:0]          num_x,
    input  logic [NUM_W-1:0]          num_y,
    input  logic [prr_pkg::DEN_W-1:0] den,
    input  prr_pkg::side_t            in_side,
    output logic                      out_valid,
    output logic [NUM_W-1:0]          quo_x,
    output logic [NUM_W-1:0]          quo_y,
    output prr_pkg::side_t            out_side
);

    localparam int DW = prr_pkg::DEN_W;

    logic [DW-1:0]    rem_x_reg [NUM_W];
    logic [DW-1:0]    rem_y_reg [NUM_W];
    logic [NUM_W-1:0] nq_x_reg  [NUM_W];
    logic [NUM_W-1:0] nq_y_reg  [NUM_W];
    logic [DW-1:0]    den_reg   [NUM_W];
    prr_pkg::side_t   side_reg  [NUM_W];
    logic             v_reg     [NUM_W];

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic [DW-1:0]    rx, ry, d;
        logic [NUM_W-1:0] qx, qy;
        prr_pkg::side_t   sd;
        logic             vi;
        logic [DW:0]      tx, ty;
        logic             gex, gey;

        if (s == 0)
        begin : g_first
            assign rx = '0;
            assign ry = '0;
            assign qx = num_x;
            assign qy = num_y;
            assign d  = den;
            assign sd = in_side;
            assign vi = in_valid;
        end
        else
        begin : g_next
            assign rx = rem_x_reg[s-1];
            assign ry = rem_y_reg[s-1];
            assign qx = nq_x_reg[s-1];
            assign qy = nq_y_reg[s-1];
            assign d  = den_reg[s-1];
            assign sd = side_reg[s-1];
            assign vi = v_reg[s-1];
        end

        assign tx  = {rx, qx[NUM_W-1]};
        assign ty  = {ry, qy[NUM_W-1]};
        assign gex = tx >= {1'b0, d};
        assign gey = ty >= {1'b0, d};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_x_reg[s] <= gex ? DW'(tx - {1'b0, d}) : tx[DW-1:0];
                rem_y_reg[s] <= gey ? DW'(ty - {1'b0, d}) : ty[DW-1:0];
                nq_x_reg[s]  <= {qx[NUM_W-2:0], gex};
                nq_y_reg[s]  <= {qy[NUM_W-2:0], gey};
                den_reg[s]   <= d;
                side_reg[s]  <= sd;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= vi;
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign quo_x     = nq_x_reg[NUM_W-1];
    assign quo_y     = nq_y_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule
